/* src/tt_pkg.sv */
`default_nettype none

package tt_pkg;

    localparam int KIND_W    = 3;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int INDEX_W   = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int CELL_W    = 16;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [KIND_W-1:0] KIND_PUT_CHAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET_COLOR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RECOLOR   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;

    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE     = 8'h20;
    localparam logic [COLOR_W-1:0] BLANK_ATTR     = 8'h07;
    localparam logic [CELL_W-1:0]  BLANK_CELL     = {BLANK_ATTR, CHAR_SPACE};

endpackage

`default_nettype wire

/* src/tt_cmd_if.sv */
`default_nettype none

interface tt_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tt_pkg::KIND_W-1:0]    kind;
    logic [tt_pkg::CHAR_W-1:0]    char_code;
    logic [tt_pkg::COLOR_W-1:0]   color_byte;
    logic [tt_pkg::INDEX_W-1:0]   cell_index;

    modport source (output valid, output kind, output char_code, output color_byte,
                    output cell_index, input ready);
    modport sink   (input valid, input kind, input char_code, input color_byte,
                    input cell_index, output ready);
endinterface

`default_nettype wire

/* src/tt_rsp_if.sv */
`default_nettype none

interface tt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tt_pkg::ROW_OUT_W-1:0]   cursor_row;
    logic [tt_pkg::COL_OUT_W-1:0]   cursor_col;
    logic [tt_pkg::COLOR_W-1:0]     current_color;
    logic [tt_pkg::CELL_W-1:0]      cell_value;

    modport source (output valid, output cursor_row, output cursor_col,
                    output current_color, output cell_value, input ready);
    modport sink   (input valid, input cursor_row, input cursor_col,
                    input current_color, input cell_value, output ready);
endinterface

`default_nettype wire

/* src/text_terminal_writer_top.sv */
// Text-mode terminal: ROWS x COLUMNS screen store of 16-bit cells
// (attribute in the high byte, character in the low byte), cursor and color.
// i_cmd carries one command per transaction (valid/ready); o_rsp returns exactly
// one result per command, in order, from an output register: cursor row and
// column, current color, and the cell read (zero for all but a read).
// Put char, set color and unused kinds: result in the output register in the
// cycle after acceptance. Read cell: goes through ST_READ to wait for the
// registered read port of the screen memory. Recolor: one read-modify-write
// per cell through the single memory write port. Clear: one cell written per
// cycle. One command is worked on at a time.
// After reset the block runs a clearing pass over all ROWS*COLUMNS cells
// (2000 by default) that fills the screen with grey-on-black spaces; i_cmd.ready
// stays low during it. Cursor resets to 0,0 and color to 0x07.
// When the receiver stalls, the result is held in the output register and
// i_cmd.ready drops until the result is taken or is taken in the same cycle.
`default_nettype none

module text_terminal_writer_top #(
    parameter int COLUMNS = tt_pkg::COLUMNS_DEF,
    parameter int ROWS    = tt_pkg::ROWS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tt_cmd_if.sink    i_cmd,
    tt_rsp_if.source  o_rsp
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

    typedef enum logic [4:0] {
        ST_INIT    = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_READ    = 5'b00100,
        ST_RECOLOR = 5'b01000,
        ST_CLEAR   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [ROW_W-1:0]           r_row, n_row;
    logic [COL_W-1:0]           r_col, n_col;
    logic [ADDR_W-1:0]          r_base, n_base;
    logic [tt_pkg::COLOR_W-1:0] r_attr, n_attr;
    logic [ADDR_W-1:0]          r_sweep, n_sweep;
    logic                       r_issue, n_issue;
    logic                       r_wpend, n_wpend;
    logic [ADDR_W-1:0]          r_wpend_addr, n_wpend_addr;
    logic                       r_rd_oor, n_rd_oor;

    logic                         r_rsp_valid, n_rsp_valid;
    logic [tt_pkg::ROW_OUT_W-1:0] r_rsp_row, n_rsp_row;
    logic [tt_pkg::COL_OUT_W-1:0] r_rsp_col, n_rsp_col;
    logic [tt_pkg::COLOR_W-1:0]   r_rsp_color, n_rsp_color;
    logic [tt_pkg::CELL_W-1:0]    r_rsp_cell, n_rsp_cell;

    logic                      accept;
    logic                      load_rsp;
    logic [tt_pkg::CELL_W-1:0] rsp_cell;
    logic [ADDR_W-1:0]         cur_addr;
    logic [ADDR_W-1:0]         next_base;
    logic [ROW_W-1:0]          next_row;

    logic                      mem_wr_en;
    logic [ADDR_W-1:0]         mem_wr_addr;
    logic [tt_pkg::CELL_W-1:0] mem_wr_data;
    logic [ADDR_W-1:0]         mem_rd_addr;
    logic [tt_pkg::CELL_W-1:0] mem_rd_data;

    tt_screen #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_rsp_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign cur_addr  = r_base + ADDR_W'(r_col);
    assign next_row  = (r_row == LAST_ROW) ? '0 : r_row + 1'b1;
    assign next_base = (r_row == LAST_ROW) ? '0 : r_base + ROW_STEP;

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_base       = r_base;
        n_attr       = r_attr;
        n_sweep      = r_sweep;
        n_issue      = r_issue;
        n_wpend      = r_wpend;
        n_wpend_addr = r_wpend_addr;
        n_rd_oor     = r_rd_oor;
        n_rsp_valid  = r_rsp_valid;
        n_rsp_row    = r_rsp_row;
        n_rsp_col    = r_rsp_col;
        n_rsp_color  = r_rsp_color;
        n_rsp_cell   = r_rsp_cell;
        load_rsp     = 1'b0;
        rsp_cell     = '0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_sweep;
        mem_wr_data  = tt_pkg::BLANK_CELL;
        mem_rd_addr  = r_sweep;

        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            ST_INIT, ST_CLEAR: begin
                mem_wr_en = 1'b1;
                if (r_sweep == LAST_ADDR) begin
                    n_sweep  = '0;
                    n_state  = ST_IDLE;
                    load_rsp = (r_state == ST_CLEAR);
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            ST_IDLE: begin
                mem_rd_addr = ADDR_W'(i_cmd.cell_index);
                if (accept) begin
                    case (i_cmd.kind)
                        tt_pkg::KIND_PUT_CHAR: begin
                            load_rsp = 1'b1;
                            if (i_cmd.char_code == tt_pkg::CHAR_NEWLINE) begin
                                n_col  = '0;
                                n_row  = next_row;
                                n_base = next_base;
                            end else if (i_cmd.char_code == tt_pkg::CHAR_BACKSPACE) begin
                                if (r_col != '0) begin
                                    n_col       = r_col - 1'b1;
                                    mem_wr_en   = 1'b1;
                                    mem_wr_addr = cur_addr - 1'b1;
                                    mem_wr_data = {r_attr, tt_pkg::CHAR_SPACE};
                                end
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = cur_addr;
                                mem_wr_data = {r_attr, i_cmd.char_code};
                                if (r_col == LAST_COL) begin
                                    n_col  = '0;
                                    n_row  = next_row;
                                    n_base = next_base;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                        end
                        tt_pkg::KIND_SET_COLOR: begin
                            n_attr   = i_cmd.color_byte;
                            load_rsp = 1'b1;
                        end
                        tt_pkg::KIND_RECOLOR: begin
                            n_attr  = i_cmd.color_byte;
                            n_sweep = '0;
                            n_issue = 1'b1;
                            n_wpend = 1'b0;
                            n_state = ST_RECOLOR;
                        end
                        tt_pkg::KIND_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_base  = '0;
                            n_attr  = tt_pkg::BLANK_ATTR;
                            n_sweep = '0;
                            n_state = ST_CLEAR;
                        end
                        tt_pkg::KIND_READ: begin
                            n_rd_oor = !(32'(i_cmd.cell_index) < 32'(CELLS));
                            n_state  = ST_READ;
                        end
                        default: begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                load_rsp = 1'b1;
                rsp_cell = r_rd_oor ? '0 : mem_rd_data;
                n_state  = ST_IDLE;
            end
            ST_RECOLOR: begin
                n_wpend      = r_issue;
                n_wpend_addr = r_sweep;
                if (r_issue) begin
                    if (r_sweep == LAST_ADDR) begin
                        n_issue = 1'b0;
                    end else begin
                        n_sweep = r_sweep + 1'b1;
                    end
                end
                if (r_wpend) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_wpend_addr;
                    mem_wr_data = {r_attr, mem_rd_data[tt_pkg::CHAR_W-1:0]};
                    if (r_wpend_addr == LAST_ADDR) begin
                        n_state  = ST_IDLE;
                        n_sweep  = '0;
                        n_wpend  = 1'b0;
                        load_rsp = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load_rsp) begin
            n_rsp_valid = 1'b1;
            n_rsp_row   = tt_pkg::ROW_OUT_W'(n_row);
            n_rsp_col   = tt_pkg::COL_OUT_W'(n_col);
            n_rsp_color = n_attr;
            n_rsp_cell  = rsp_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_attr      <= tt_pkg::BLANK_ATTR;
            r_sweep     <= '0;
            r_issue     <= 1'b0;
            r_wpend     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_attr      <= n_attr;
            r_sweep     <= n_sweep;
            r_issue     <= n_issue;
            r_wpend     <= n_wpend;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wpend_addr <= n_wpend_addr;
        r_rd_oor     <= n_rd_oor;
        r_rsp_row    <= n_rsp_row;
        r_rsp_col    <= n_rsp_col;
        r_rsp_color  <= n_rsp_color;
        r_rsp_cell   <= n_rsp_cell;
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.cursor_row    = r_rsp_row;
    assign o_rsp.cursor_col    = r_rsp_col;
    assign o_rsp.current_color = r_rsp_color;
    assign o_rsp.cell_value    = r_rsp_cell;

endmodule

`default_nettype wire

/* src/tt_screen.sv */
`default_nettype none

module tt_screen #(
    parameter int DEPTH  = tt_pkg::COLUMNS_DEF * tt_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [ADDR_W-1:0]         i_wr_addr,
    input  wire logic [tt_pkg::CELL_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]         i_rd_addr,
    output wire logic [tt_pkg::CELL_W-1:0] o_rd_data
);

    logic [tt_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tt_pkg::CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int COLUMNS = tt_pkg::COLUMNS_DEF;
    localparam int ROWS    = tt_pkg::ROWS_DEF;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int INDEX_MAX = (1 << tt_pkg::INDEX_W) - 1;

    localparam logic [tt_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [tt_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS  = 600;
    localparam int HOLD_OFF_AT   = 200;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int DRAIN_AT      = 350;
    localparam int SETTLE_CYCLES = 2100;
    localparam int REPORT_MAX    = 100;

    typedef struct packed {
        logic [tt_pkg::KIND_W-1:0]  kind;
        logic [tt_pkg::CHAR_W-1:0]  char_code;
        logic [tt_pkg::COLOR_W-1:0] color_byte;
        logic [tt_pkg::INDEX_W-1:0] cell_index;
    } t_term_cmd;

    typedef struct packed {
        logic [tt_pkg::ROW_OUT_W-1:0] cursor_row;
        logic [tt_pkg::COL_OUT_W-1:0] cursor_col;
        logic [tt_pkg::COLOR_W-1:0]   current_color;
        logic [tt_pkg::CELL_W-1:0]    cell_value;
    } t_term_view;

    typedef struct {
        t_term_cmd cmd;
        bit        drain_first;
    } t_queued_cmd;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tt_cmd_if cmd_bus ();
    tt_rsp_if rsp_bus ();

    text_terminal_writer_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus),
        .o_rsp  (rsp_bus)
    );

    always #1 i_clk = ~i_clk;

    // screen shadow
    logic [tt_pkg::CELL_W-1:0]    screen_model [CELLS];
    logic [tt_pkg::ROW_OUT_W-1:0] row_now;
    logic [tt_pkg::COL_OUT_W-1:0] col_now;
    logic [tt_pkg::COLOR_W-1:0]   attr_now;

    t_queued_cmd pending_cmds[$];
    t_term_view  expected_views[$];
    t_term_cmd   in_flight;
    int          total_cmds;
    int          accepted_cnt = 0;
    int          results_seen = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned stall_phase = 0;
    int          report_cnt = 0;
    bit          mismatch_seen = 1'b0;

    function automatic void wipe_model();
        foreach (screen_model[i]) screen_model[i] = tt_pkg::BLANK_CELL;
        row_now  = '0;
        col_now  = '0;
        attr_now = tt_pkg::BLANK_ATTR;
    endfunction

    function automatic void advance_row();
        col_now = '0;
        row_now = (row_now == ROWS - 1) ? '0 : row_now + 1'b1;
    endfunction

    function automatic t_term_view apply_command(t_term_cmd c);
        t_term_view v;
        v = '0;
        case (c.kind)
            tt_pkg::KIND_PUT_CHAR: begin
                if (c.char_code == tt_pkg::CHAR_NEWLINE) begin
                    advance_row();
                end else if (c.char_code == tt_pkg::CHAR_BACKSPACE) begin
                    if (col_now != 0) begin
                        col_now = col_now - 1'b1;
                        screen_model[row_now * COLUMNS + col_now] =
                            {attr_now, tt_pkg::CHAR_SPACE};
                    end
                end else begin
                    screen_model[row_now * COLUMNS + col_now] = {attr_now, c.char_code};
                    if (col_now == COLUMNS - 1) advance_row();
                    else col_now = col_now + 1'b1;
                end
            end
            tt_pkg::KIND_SET_COLOR: attr_now = c.color_byte;
            tt_pkg::KIND_RECOLOR: begin
                attr_now = c.color_byte;
                foreach (screen_model[i])
                    screen_model[i][tt_pkg::CELL_W-1:tt_pkg::CHAR_W] = attr_now;
            end
            tt_pkg::KIND_CLEAR: wipe_model();
            tt_pkg::KIND_READ: begin
                if (c.cell_index < CELLS) v.cell_value = screen_model[c.cell_index];
            end
            default: ;
        endcase
        v.cursor_row    = row_now;
        v.cursor_col    = col_now;
        v.current_color = attr_now;
        return v;
    endfunction

    function automatic t_term_cmd make_cmd(logic [tt_pkg::KIND_W-1:0] kind, int unsigned arg);
        t_term_cmd c;
        c.kind       = kind;
        c.char_code  = tt_pkg::CHAR_W'($urandom);
        c.color_byte = tt_pkg::COLOR_W'($urandom);
        c.cell_index = tt_pkg::INDEX_W'($urandom);
        case (kind)
            tt_pkg::KIND_PUT_CHAR: c.char_code = arg[tt_pkg::CHAR_W-1:0];
            tt_pkg::KIND_SET_COLOR, tt_pkg::KIND_RECOLOR:
                c.color_byte = arg[tt_pkg::COLOR_W-1:0];
            tt_pkg::KIND_READ: c.cell_index = arg[tt_pkg::INDEX_W-1:0];
            default: ;
        endcase
        return c;
    endfunction

    function automatic void add_cmd(t_term_cmd c);
        t_queued_cmd q;
        q.cmd         = c;
        q.drain_first = 1'b0;
        pending_cmds.push_back(q);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_seen = 1'b1;
            if (report_cnt < REPORT_MAX)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            report_cnt++;
        end
    endfunction

    // command driver
    always @(posedge i_clk) begin
        t_queued_cmd q;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                expected_views.push_back(apply_command(in_flight));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_bus.valid <= 1'b0;
                end else if (pending_cmds.size() == 0 ||
                             (pending_cmds[0].drain_first &&
                              (cmd_bus.valid || accepted_cnt != results_seen))) begin
                    cmd_bus.valid <= 1'b0;
                end else begin
                    q = pending_cmds.pop_front();
                    in_flight = q.cmd;
                    cmd_bus.valid      <= 1'b1;
                    cmd_bus.kind       <= q.cmd.kind;
                    cmd_bus.char_code  <= q.cmd.char_code;
                    cmd_bus.color_byte <= q.cmd.color_byte;
                    cmd_bus.cell_index <= q.cmd.cell_index;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_term_view want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            stall_phase++;
            if (rsp_bus.valid && rsp_bus.ready) begin
                results_seen <= results_seen + 1;
                if (expected_views.size() == 0) begin
                    mismatch_seen = 1'b1;
                    $error("result with no command outstanding: row %0d col %0d color 0x%0h",
                           rsp_bus.cursor_row, rsp_bus.cursor_col, rsp_bus.current_color);
                end else begin
                    want = expected_views.pop_front();
                    check_field("cursor_row", 32'(want.cursor_row), 32'(rsp_bus.cursor_row));
                    check_field("cursor_col", 32'(want.cursor_col), 32'(rsp_bus.cursor_col));
                    check_field("current_color", 32'(want.current_color),
                                32'(rsp_bus.current_color));
                    check_field("cell_value", 32'(want.cell_value), 32'(rsp_bus.cell_value));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (!hold_done && results_seen == HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_LEN;
                rsp_bus.ready <= 1'b0;
            end else begin
                case (stall_phase[8:7])
                    2'd0:    rsp_bus.ready <= 1'b1;
                    2'd1:    rsp_bus.ready <= 1'($urandom_range(1));
                    2'd2:    rsp_bus.ready <= ($urandom_range(3) != 0);
                    default: rsp_bus.ready <= (stall_phase[1:0] == 2'd0);
                endcase
            end
        end
    end

    initial begin
        int pick;
        int len;
        int r;
        int random_start;
        t_term_cmd c;

        cmd_bus.valid      = 1'b0;
        cmd_bus.kind       = tt_pkg::KIND_PUT_CHAR;
        cmd_bus.char_code  = '0;
        cmd_bus.color_byte = '0;
        cmd_bus.cell_index = '0;
        rsp_bus.ready      = 1'b0;
        wipe_model();

        // directed
        add_cmd(make_cmd(tt_pkg::KIND_READ, 0));
        add_cmd(make_cmd(tt_pkg::KIND_READ, CELLS - 1));
        add_cmd(make_cmd(tt_pkg::KIND_READ, CELLS));
        add_cmd(make_cmd(tt_pkg::KIND_READ, INDEX_MAX));
        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, 8'h00));
        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, 8'hFF));
        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, tt_pkg::CHAR_BACKSPACE));
        add_cmd(make_cmd(tt_pkg::KIND_READ, 1));
        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, tt_pkg::CHAR_BACKSPACE));
        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, tt_pkg::CHAR_BACKSPACE));
        add_cmd(make_cmd(tt_pkg::KIND_SET_COLOR, 8'hFF));
        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, 8'h41));
        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, 8'h7F));
        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, tt_pkg::CHAR_NEWLINE));
        add_cmd(make_cmd(tt_pkg::KIND_READ, 0));
        add_cmd(make_cmd(tt_pkg::KIND_SET_COLOR, 8'h00));
        add_cmd(make_cmd(tt_pkg::KIND_RECOLOR, 8'hA5));
        add_cmd(make_cmd(tt_pkg::KIND_READ, 1));
        add_cmd(make_cmd(tt_pkg::KIND_READ, CELLS - 1));
        add_cmd(make_cmd(KIND_SPARE_LO, 0));
        add_cmd('1);
        add_cmd(make_cmd(tt_pkg::KIND_CLEAR, 0));
        add_cmd(make_cmd(tt_pkg::KIND_READ, 0));

        // random text and newline runs, reads, set color, recolor, clear, random kinds
        random_start = pending_cmds.size();
        while (pending_cmds.size() - random_start < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
                repeat (len) begin
                    r = $urandom_range(19);
                    if (r == 0)
                        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, tt_pkg::CHAR_BACKSPACE));
                    else if (r == 1)
                        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, $urandom_range(255)));
                    else
                        add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR,
                                         $urandom_range(8'h7E, 8'h20)));
                end
                if ($urandom_range(1))
                    add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, tt_pkg::CHAR_NEWLINE));
            end else if (pick < 55) begin
                repeat ($urandom_range(1, 30))
                    add_cmd(make_cmd(tt_pkg::KIND_PUT_CHAR, tt_pkg::CHAR_NEWLINE));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(9);
                    if (r < 6)
                        add_cmd(make_cmd(tt_pkg::KIND_READ, $urandom_range(4 * COLUMNS)));
                    else if (r < 8)
                        add_cmd(make_cmd(tt_pkg::KIND_READ, $urandom_range(CELLS - 1)));
                    else
                        add_cmd(make_cmd(tt_pkg::KIND_READ, $urandom_range(INDEX_MAX)));
                end
            end else if (pick < 85) begin
                add_cmd(make_cmd(tt_pkg::KIND_SET_COLOR, $urandom_range(255)));
            end else if (pick < 88) begin
                add_cmd(make_cmd(tt_pkg::KIND_RECOLOR, $urandom_range(255)));
            end else if (pick < 90) begin
                add_cmd(make_cmd(tt_pkg::KIND_CLEAR, 0));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    c = make_cmd(tt_pkg::KIND_W'($urandom_range(KIND_SPARE_HI)), $urandom);
                    add_cmd(c);
                end
            end
        end
        pending_cmds[random_start + DRAIN_AT].drain_first = 1'b1;
        total_cmds = pending_cmds.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt != total_cmds || results_seen != total_cmds) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_views.size() != 0) begin
            mismatch_seen = 1'b1;
            $error("%0d results never arrived", expected_views.size());
        end
        if (!mismatch_seen) begin
            $display("text_terminal_writer_top verification clean");
        end else begin
            $display("text_terminal_writer_top verification failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("text_terminal_writer_top verification failed");
        $finish;
    end

endmodule
